// File: design/gpg_pkg.sv
// Package for the gradient pattern generator: field widths, datapath widths,
// register codes and register reset values. It depends on nothing else.
`default_nettype none

package gpg_pkg;

    // Widths of the pixel coordinates, frame dimensions and colors.
    localparam int ROW_W   = 12;
    localparam int DIM_W   = 13;
    localparam int SUM_W   = DIM_W + 1;
    localparam int COLOR_W = 24;
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * ROW_W;

    // Square root datapath: a radicand of up to 42 bits gives a 21 bit root.
    localparam int ROOT_W = 21;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Divisor width covers both the corner distance and the width plus height sum.
    localparam int DIV_W = ROOT_W;

    // Configuration port address width: five 32 bit registers.
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_START  = 3'd3,
        REG_END    = 3'd4
    } t_reg_idx;

    localparam logic               RST_MODE   = 1'b0;
    localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd480;
    localparam logic [COLOR_W-1:0] RST_START  = 24'h000000;
    localparam logic [COLOR_W-1:0] RST_END    = 24'hFFFFFF;

endpackage

`default_nettype wire

// File: design/gpg_sqrt_cell.sv
// One cell of the pipelined square root chain: settles one root bit per cycle.
// Depends on gpg_pkg for the datapath widths.
`default_nettype none

module gpg_sqrt_cell (
    input  logic                       i_clk,
    input  logic [gpg_pkg::REM_W-1:0]  i_rem,
    input  logic [gpg_pkg::ROOT_W-1:0] i_root,
    input  logic [gpg_pkg::RAD_W-1:0]  i_rad,
    output logic [gpg_pkg::REM_W-1:0]  o_rem,
    output logic [gpg_pkg::ROOT_W-1:0] o_root,
    output logic [gpg_pkg::RAD_W-1:0]  o_rad
);
    import gpg_pkg::*;

    logic [REM_W+1:0]  w_cur;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [RAD_W-1:0]  r_rad;

    // Bring down the next two radicand bits and try the root bit as one.
    always_comb begin
        w_cur   = {i_rem, i_rad[RAD_W-1 -: 2]};
        w_trial = (REM_W + 2)'({i_root, 2'b01});
        w_ge    = (w_cur >= w_trial);
        w_diff  = w_cur - w_trial;
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
        r_root <= {i_root[ROOT_W-2:0], w_ge};
        r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

`default_nettype wire

// File: design/gpg_div_cell.sv
// One cell of the pipelined restoring divider: settles one quotient bit per cycle.
// Depends on gpg_pkg for the divisor width.
`default_nettype none

module gpg_div_cell #(
    parameter int NUM_W = 37
) (
    input  logic                      i_clk,
    input  logic [gpg_pkg::DIV_W-1:0] i_rem,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [gpg_pkg::DIV_W-1:0] i_den,
    output logic [gpg_pkg::DIV_W-1:0] o_rem,
    output logic [NUM_W-1:0]          o_num,
    output logic [gpg_pkg::DIV_W-1:0] o_den
);
    import gpg_pkg::*;

    logic [DIV_W:0]   w_cur;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;
    logic [DIV_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [DIV_W-1:0] r_den;

    // The numerator register fills from the bottom with quotient bits.
    always_comb begin
        w_cur  = {i_rem, i_num[NUM_W-1]};
        w_ge   = (w_cur >= {1'b0, i_den});
        w_diff = w_cur - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_cur[DIV_W-1:0];
        r_num <= {i_num[NUM_W-2:0], w_ge};
        r_den <= i_den;
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

`default_nettype wire

// File: design/gpg_mix.sv
// Blends one color channel with two signed weights, then truncates and clamps.
// Two register stages; depends on gpg_pkg for the channel width.
`default_nettype none

module gpg_mix #(
    parameter int FRAC_W = 16,
    parameter int WGT_W  = 39
) (
    input  logic                     i_clk,
    input  logic [gpg_pkg::CH_W-1:0] i_a,
    input  logic [gpg_pkg::CH_W-1:0] i_b,
    input  logic signed [WGT_W-1:0]  i_wa,
    input  logic signed [WGT_W-1:0]  i_wb,
    output logic [gpg_pkg::CH_W-1:0] o_ch
);
    import gpg_pkg::*;

    localparam int PW = WGT_W + CH_W + 1;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] r_pa;
    logic signed [PW-1:0] r_pb;
    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_shift;
    logic [CH_W-1:0]      n_ch;
    logic [CH_W-1:0]      r_ch;

    always_ff @(posedge i_clk) begin
        r_pa <= PW'($signed({1'b0, i_a})) * PW'(i_wa);
        r_pb <= PW'($signed({1'b0, i_b})) * PW'(i_wb);
    end

    // A negative sum gives zero, a sum above full scale gives full scale.
    always_comb begin
        w_sum   = SW'(r_pa) + SW'(r_pb);
        w_shift = w_sum >>> FRAC_W;
        if (w_sum[SW-1]) begin
            n_ch = '0;
        end else if (w_shift > SW'(255)) begin
            n_ch = '1;
        end else begin
            n_ch = w_shift[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
    end

    assign o_ch = r_ch;

endmodule

`default_nettype wire

// File: design/gradient_pattern_generator.sv
// Top level of the gradient pattern generator: configuration registers, input
// stage, square root and divider cell chains, weight stage and channel blenders.
// Depends on gpg_pkg, gpg_sqrt_cell, gpg_div_cell and gpg_mix.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+-----------
//   command  | start, busy, i_pixel_row, i_pixel_col     | in/out
//   result   | o_valid, o_red_out, o_green_out, o_blue_out| out
//   config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//            | prdata, pready                            |
//
// The block takes one pixel beat per clock while busy is low and returns one
// result beat per pixel. A pixel passes through the input stage register, the
// square root chain (one cell per root bit), the divider chain (one cell per
// quotient bit), the weight stage register and the two blender register stages.
// busy is high only during reset. A result beat is on the ports for one cycle
// with o_valid high; the receiver cannot stall it, so nothing holds back.
`default_nettype none

module gradient_pattern_generator #(
    parameter int MAX_DIM          = 4096,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [gpg_pkg::ROW_W-1:0]     i_pixel_row,
    input  logic [gpg_pkg::ROW_W-1:0]     i_pixel_col,
    // Result channel.
    output logic                          o_valid,
    output logic [gpg_pkg::CH_W-1:0]      o_red_out,
    output logic [gpg_pkg::CH_W-1:0]      o_green_out,
    output logic [gpg_pkg::CH_W-1:0]      o_blue_out,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gpg_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gpg_pkg::*;

    // The quotient holds a root with WEIGHT_FRAC_BITS more fraction bits.
    localparam int NUM_W = ROOT_W + WEIGHT_FRAC_BITS;
    // Weights are signed and may exceed one for pixels outside the frame.
    localparam int WGT_W = NUM_W + 2;
    localparam int LAT   = ROOT_W + NUM_W + 4;

    // Side information that rides along with the square root chain.
    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [DIM_W-1:0] dnum;
        logic [SUM_W-1:0] dden;
    } t_sq_side;

    // Side information that rides along with the divider chain.
    typedef struct packed {
        logic valid;
        logic mode;
        logic mzero;
    } t_dv_side;

    //------------------------------------------------------------------
    // Configuration registers. Writes keep only each register's width;
    // an address beyond the list is ignored.
    //------------------------------------------------------------------
    logic               r_mode;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [COLOR_W-1:0] r_start;
    logic [COLOR_W-1:0] r_end;
    logic               w_cfg_wr;
    t_reg_idx           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_start  <= RST_START;
            r_end    <= RST_END;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_MODE:   r_mode   <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_START:  r_start  <= pwdata[COLOR_W-1:0];
                REG_END:    r_end    <= pwdata[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_MODE:   prdata = 32'(r_mode);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_START:  prdata = 32'(r_start);
            REG_END:    prdata = 32'(r_end);
            default:    prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Input stage. The dimensions are clamped into one to MAX_DIM, the
    // center offsets are taken as magnitudes and squared, and both
    // radicands carry sixteen extra zero bits so that the roots come out
    // with eight fraction bits. The diagonal numerator and denominator are
    // formed here as well.
    //------------------------------------------------------------------
    logic                w_accept;
    logic [DIM_W-1:0]    w_w;
    logic [DIM_W-1:0]    w_h;
    logic [ROW_W-1:0]    w_hw;
    logic [ROW_W-1:0]    w_hh;
    logic [ROW_W-1:0]    w_dx;
    logic [ROW_W-1:0]    w_dy;
    logic [SQ_W:0]       w_dist_sq;
    logic [SQ_W:0]       w_corner_sq;
    t_sq_side            r_s1_side;
    logic [RAD_W-1:0]    r_s1_rad_d;
    logic [RAD_W-1:0]    r_s1_rad_m;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    always_comb begin
        if (r_width == '0) begin
            w_w = DIM_W'(1);
        end else if (32'(r_width) > MAX_DIM) begin
            w_w = DIM_W'(MAX_DIM);
        end else begin
            w_w = r_width;
        end
        if (r_height == '0) begin
            w_h = DIM_W'(1);
        end else if (32'(r_height) > MAX_DIM) begin
            w_h = DIM_W'(MAX_DIM);
        end else begin
            w_h = r_height;
        end
        w_hw = w_w[DIM_W-1:1];
        w_hh = w_h[DIM_W-1:1];
        w_dx = (w_hw >= i_pixel_col) ? (w_hw - i_pixel_col) : (i_pixel_col - w_hw);
        w_dy = (w_hh >= i_pixel_row) ? (w_hh - i_pixel_row) : (i_pixel_row - w_hh);
        w_dist_sq   = (SQ_W + 1)'(w_dx) * (SQ_W + 1)'(w_dx)
                    + (SQ_W + 1)'(w_dy) * (SQ_W + 1)'(w_dy);
        w_corner_sq = (SQ_W + 1)'(w_hw) * (SQ_W + 1)'(w_hw)
                    + (SQ_W + 1)'(w_hh) * (SQ_W + 1)'(w_hh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side.valid <= 1'b0;
        end else begin
            r_s1_side.valid <= w_accept;
        end
        r_s1_side.mode <= r_mode;
        r_s1_side.dnum <= DIM_W'(i_pixel_row) + DIM_W'(i_pixel_col) + DIM_W'(1);
        r_s1_side.dden <= SUM_W'(w_w) + SUM_W'(w_h);
        r_s1_rad_d     <= RAD_W'({w_dist_sq, 16'h0000});
        r_s1_rad_m     <= RAD_W'({w_corner_sq, 16'h0000});
    end

    //------------------------------------------------------------------
    // Square root chain: two lanes, one for the pixel distance and one for
    // the corner distance, each with one cell per root bit.
    //------------------------------------------------------------------
    logic [REM_W-1:0]  w_d_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_d_root [ROOT_W+1];
    logic [RAD_W-1:0]  w_d_rad  [ROOT_W+1];
    logic [REM_W-1:0]  w_m_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] w_m_root [ROOT_W+1];
    logic [RAD_W-1:0]  w_m_rad  [ROOT_W+1];
    t_sq_side          r_sq_side [ROOT_W];

    assign w_d_rem[0]  = '0;
    assign w_d_root[0] = '0;
    assign w_d_rad[0]  = r_s1_rad_d;
    assign w_m_rem[0]  = '0;
    assign w_m_root[0] = '0;
    assign w_m_rad[0]  = r_s1_rad_m;

    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
        gpg_sqrt_cell u_sqrt_d (
            .i_clk  (i_clk),
            .i_rem  (w_d_rem[gi]),
            .i_root (w_d_root[gi]),
            .i_rad  (w_d_rad[gi]),
            .o_rem  (w_d_rem[gi+1]),
            .o_root (w_d_root[gi+1]),
            .o_rad  (w_d_rad[gi+1])
        );
        gpg_sqrt_cell u_sqrt_m (
            .i_clk  (i_clk),
            .i_rem  (w_m_rem[gi]),
            .i_root (w_m_root[gi]),
            .i_rad  (w_m_rad[gi]),
            .o_rem  (w_m_rem[gi+1]),
            .o_root (w_m_root[gi+1]),
            .o_rad  (w_m_rad[gi+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[gi].valid <= 1'b0;
            end else if (gi == 0) begin
                r_sq_side[gi].valid <= r_s1_side.valid;
            end else begin
                r_sq_side[gi].valid <= r_sq_side[(gi == 0) ? 0 : gi-1].valid;
            end
            if (gi == 0) begin
                r_sq_side[gi].mode <= r_s1_side.mode;
                r_sq_side[gi].dnum <= r_s1_side.dnum;
                r_sq_side[gi].dden <= r_s1_side.dden;
            end else begin
                r_sq_side[gi].mode <= r_sq_side[(gi == 0) ? 0 : gi-1].mode;
                r_sq_side[gi].dnum <= r_sq_side[(gi == 0) ? 0 : gi-1].dnum;
                r_sq_side[gi].dden <= r_sq_side[(gi == 0) ? 0 : gi-1].dden;
            end
        end
    end

    //------------------------------------------------------------------
    // Divider chain. In radial mode the pixel root, scaled up, is divided by
    // the corner root; a zero corner root forces the weight to zero. In
    // diagonal mode the position sum, scaled up, is divided by width plus
    // height.
    //------------------------------------------------------------------
    logic [DIV_W-1:0] w_q_rem [NUM_W+1];
    logic [NUM_W-1:0] w_q_num [NUM_W+1];
    logic [DIV_W-1:0] w_q_den [NUM_W+1];
    t_dv_side         w_dv_in;
    t_dv_side         r_dv_side [NUM_W];

    always_comb begin
        w_q_rem[0] = '0;
        if (r_sq_side[ROOT_W-1].mode) begin
            w_q_num[0] = NUM_W'(r_sq_side[ROOT_W-1].dnum) << WEIGHT_FRAC_BITS;
            w_q_den[0] = DIV_W'(r_sq_side[ROOT_W-1].dden);
        end else begin
            w_q_num[0] = {w_d_root[ROOT_W], {WEIGHT_FRAC_BITS{1'b0}}};
            w_q_den[0] = w_m_root[ROOT_W];
        end
        w_dv_in.valid = r_sq_side[ROOT_W-1].valid;
        w_dv_in.mode  = r_sq_side[ROOT_W-1].mode;
        w_dv_in.mzero = !r_sq_side[ROOT_W-1].mode && (w_m_root[ROOT_W] == '0);
    end

    for (genvar gj = 0; gj < NUM_W; gj++) begin : g_div
        gpg_div_cell #(
            .NUM_W (NUM_W)
        ) u_div (
            .i_clk (i_clk),
            .i_rem (w_q_rem[gj]),
            .i_num (w_q_num[gj]),
            .i_den (w_q_den[gj]),
            .o_rem (w_q_rem[gj+1]),
            .o_num (w_q_num[gj+1]),
            .o_den (w_q_den[gj+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[gj].valid <= 1'b0;
            end else if (gj == 0) begin
                r_dv_side[gj].valid <= w_dv_in.valid;
            end else begin
                r_dv_side[gj].valid <= r_dv_side[(gj == 0) ? 0 : gj-1].valid;
            end
            if (gj == 0) begin
                r_dv_side[gj].mode  <= w_dv_in.mode;
                r_dv_side[gj].mzero <= w_dv_in.mzero;
            end else begin
                r_dv_side[gj].mode  <= r_dv_side[(gj == 0) ? 0 : gj-1].mode;
                r_dv_side[gj].mzero <= r_dv_side[(gj == 0) ? 0 : gj-1].mzero;
            end
        end
    end

    //------------------------------------------------------------------
    // Weight stage. Radial mode weights the start color by p, diagonal mode
    // weights the end color by p; the other color takes one minus p.
    //------------------------------------------------------------------
    logic [NUM_W-1:0]        w_p;
    logic signed [WGT_W-1:0] w_p_s;
    logic signed [WGT_W-1:0] w_one_minus;
    logic signed [WGT_W-1:0] r_ws;
    logic signed [WGT_W-1:0] r_we;
    logic                    r_w_valid;
    logic [1:0]              r_mx_valid;

    always_comb begin
        w_p         = r_dv_side[NUM_W-1].mzero ? '0 : w_q_num[NUM_W];
        w_p_s       = $signed(WGT_W'(w_p));
        w_one_minus = ($signed(WGT_W'(1)) <<< WEIGHT_FRAC_BITS) - w_p_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid  <= 1'b0;
            r_mx_valid <= '0;
        end else begin
            r_w_valid  <= r_dv_side[NUM_W-1].valid;
            r_mx_valid <= {r_mx_valid[0], r_w_valid};
        end
        r_ws <= r_dv_side[NUM_W-1].mode ? w_one_minus : w_p_s;
        r_we <= r_dv_side[NUM_W-1].mode ? w_p_s : w_one_minus;
    end

    //------------------------------------------------------------------
    // Channel blenders. The colors are read straight from the registers; the user
    // must change them only while no pixel is in flight, which the block does not enforce.
    //------------------------------------------------------------------
    gpg_mix #(
        .FRAC_W (WEIGHT_FRAC_BITS),
        .WGT_W  (WGT_W)
    ) u_mix_red (
        .i_clk (i_clk),
        .i_a   (r_start[23:16]),
        .i_b   (r_end[23:16]),
        .i_wa  (r_ws),
        .i_wb  (r_we),
        .o_ch  (o_red_out)
    );

    gpg_mix #(
        .FRAC_W (WEIGHT_FRAC_BITS),
        .WGT_W  (WGT_W)
    ) u_mix_green (
        .i_clk (i_clk),
        .i_a   (r_start[15:8]),
        .i_b   (r_end[15:8]),
        .i_wa  (r_ws),
        .i_wb  (r_we),
        .o_ch  (o_green_out)
    );

    gpg_mix #(
        .FRAC_W (WEIGHT_FRAC_BITS),
        .WGT_W  (WGT_W)
    ) u_mix_blue (
        .i_clk (i_clk),
        .i_a   (r_start[7:0]),
        .i_b   (r_end[7:0]),
        .i_wa  (r_ws),
        .i_wb  (r_we),
        .o_ch  (o_blue_out)
    );

    assign o_valid = r_mx_valid[1];

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------

    // Every result beat comes from an earlier pixel beat.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result beat without a matching pixel beat");

    // Every pixel beat yields a result beat.
    a_pixel_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("pixel beat lost in the pipeline");

    // The zero corner distance override only arises in radial mode.
    a_mzero_radial_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_side[0].mzero |-> !r_dv_side[0].mode)
        else $error("zero corner flag raised in diagonal mode");

endmodule

`default_nettype wire

// File: tb/sv/gpg_scoreboard.sv
// Scoreboard for the gradient pattern generator: a bit-exact pixel color
// predictor and a queue of expected colors. Depends on nothing but the language.
`timescale 1ns / 100ps

class gpg_scoreboard;
    // Shadow copy of the configuration registers.
    bit        mode_diag;
    bit [12:0] frame_w;
    bit [12:0] frame_h;
    bit [23:0] color_a;
    bit [23:0] color_b;

    bit [23:0] pending_colors[$];
    int        mismatches;
    int        checked;

    function new();
        mode_diag = 1'b0;
        frame_w = 13'd640;
        frame_h = 13'd480;
        color_a = 24'h000000;
        color_b = 24'hFFFFFF;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_reg(int idx, bit [31:0] value);
        case (idx)
            0: mode_diag = value[0];
            1: frame_w = value[12:0];
            2: frame_h = value[12:0];
            3: color_a = value[23:0];
            4: color_b = value[23:0];
            default: ;
        endcase
    endfunction

    // Integer square root, bit by bit, on a 64 bit radicand.
    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function bit [7:0] blend(longint a, longint b, longint wa, longint wb);
        longint s;
        s = a * wa + b * wb;
        if (s < 0) return 8'd0;
        s = s >>> 16;
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function bit [23:0] predict_rgb(bit [11:0] row, bit [11:0] col);
        longint w, h, hw, hh, dx, dy, p, ws, we;
        longint unsigned d, m;
        bit [23:0] rgb;
        w = (frame_w < 1) ? 1 : (frame_w > 4096) ? 4096 : frame_w;
        h = (frame_h < 1) ? 1 : (frame_h > 4096) ? 4096 : frame_h;
        if (!mode_diag) begin
            hw = w / 2;
            hh = h / 2;
            dx = hw - col;
            dy = hh - row;
            d = int_sqrt(longint'(dx * dx + dy * dy) << 16);
            m = int_sqrt(longint'(hw * hw + hh * hh) << 16);
            p = (m == 0) ? 0 : longint'((d << 16) / m);
            ws = p;
            we = 65536 - p;
        end else begin
            p = ((longint'(row) + col + 1) << 16) / (h + w);
            ws = 65536 - p;
            we = p;
        end
        for (int ch = 0; ch < 3; ch++)
            rgb[16 - 8 * ch +: 8] = blend(color_a[16 - 8 * ch +: 8],
                                          color_b[16 - 8 * ch +: 8], ws, we);
        return rgb;
    endfunction

    function void note_pixel(bit [11:0] row, bit [11:0] col);
        pending_colors.push_back(predict_rgb(row, col));
    endfunction

    function void check_color(bit [7:0] r, bit [7:0] g, bit [7:0] b);
        bit [23:0] want;
        if (pending_colors.size() == 0) begin
            $display("%0t: unexpected result beat %h %h %h", $time, r, g, b);
            mismatches++;
            return;
        end
        want = pending_colors.pop_front();
        checked++;
        if (want[23:16] !== r) begin
            $display("%0t: red expected %0d actual %0d", $time, want[23:16], r);
            mismatches++;
        end
        if (want[15:8] !== g) begin
            $display("%0t: green expected %0d actual %0d", $time, want[15:8], g);
            mismatches++;
        end
        if (want[7:0] !== b) begin
            $display("%0t: blue expected %0d actual %0d", $time, want[7:0], b);
            mismatches++;
        end
    endfunction
endclass

// File: tb/sv/testbench.sv
// Top-level testbench for gradient_pattern_generator: drives pixel beats and
// register writes, checks every result beat. Depends on gpg_pkg, gpg_scoreboard.
`timescale 1ns / 100ps

module testbench;
    import gpg_pkg::*;

    // Result latency of the design, equal to its LAT at the default parameters.
    localparam int LATENCY   = 62;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] i_pixel_row = '0;
    logic [11:0] i_pixel_col = '0;
    logic        o_valid;
    logic [7:0]  o_red_out, o_green_out, o_blue_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gpg_scoreboard color_board = new();
    int          cycle_count = 0;
    int          pixels_sent = 0;
    bit          quiet_tail = 1'b0;

    always #5 i_clk = ~i_clk;

    gradient_pattern_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_row(i_pixel_row), .i_pixel_col(i_pixel_col),
        .o_valid(o_valid), .o_red_out(o_red_out), .o_green_out(o_green_out),
        .o_blue_out(o_blue_out), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // Results cannot be stalled, so every strobed beat is checked at once.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid)
            color_board.check_color(o_red_out, o_green_out, o_blue_out);
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("gradient_pattern_generator verification failed");
            $finish;
        end
    end

    // A register write has a setup phase and an access phase; pready is
    // always high, so the register updates at the end of the access phase.
    // An idle phase follows so the next write starts on a later edge.
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        color_board.set_reg(int'(idx), value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drive one pixel beat; start stays high when the next beat follows
    // back to back, so it is never lowered and raised in the same step.
    task automatic send_pixel(logic [11:0] row, logic [11:0] col);
        start       <= 1'b1;
        i_pixel_row <= row;
        i_pixel_col <= col;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        color_board.note_pixel(row, col);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Wait until all results are in, then let the pipeline drain fully.
    task automatic drain();
        start <= 1'b0;
        while (color_board.pending_colors.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Random pixel, mostly inside the frame, sometimes anywhere in 12 bits.
    task automatic random_pixel();
        int w, h;
        w = (color_board.frame_w == 0) ? 1 : color_board.frame_w;
        h = (color_board.frame_h == 0) ? 1 : color_board.frame_h;
        if ($urandom_range(0, 9) < 8)
            send_pixel(12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1)),
                       12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1)));
        else
            send_pixel(12'($urandom), 12'($urandom));
        sender_gap();
    endtask

    task automatic random_config();
        int pick;
        write_reg(REG_MODE, $urandom);
        pick = $urandom_range(0, 5);
        // Mix of extremes, tiny frames and random sizes; unused bits random in some writes.
        case (pick)
            0: write_reg(REG_WIDTH, {$urandom} & 32'hFFFF_E000 | 32'd4096);
            1: write_reg(REG_WIDTH, 32'd1);
            default: write_reg(REG_WIDTH, $urandom);
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
            0: write_reg(REG_HEIGHT, 32'd4096);
            1: write_reg(REG_HEIGHT, 32'd0);
            default: write_reg(REG_HEIGHT, $urandom);
        endcase
        write_reg(REG_START, $urandom);
        write_reg(REG_END, $urandom);
    endtask

    initial begin
        int phase;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset values: center, corners, outside the frame.
        send_pixel(12'd240, 12'd320);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd479, 12'd639);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'hFFF);
        drain();
        // Diagonal mode with saturating and zero dimensions and full colors.
        write_reg(REG_MODE, 32'hFFFF_FFFF);
        write_reg(REG_WIDTH, 32'h0000_1FFF);
        write_reg(REG_HEIGHT, 32'hFFFF_0000);
        write_reg(REG_START, 32'hFFFF_FFFF);
        write_reg(REG_END, 32'h0000_0000);
        write_reg(t_reg_idx'(3'd7), 32'h1234_5678);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();
        // Radial mode with a 1x1 frame gives a zero corner distance.
        write_reg(REG_MODE, 32'd0);
        write_reg(REG_WIDTH, 32'd1);
        write_reg(REG_HEIGHT, 32'd1);
        write_reg(REG_START, 32'h12_34_56);
        write_reg(REG_END, 32'hAB_CD_EF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd3, 12'd7);
        drain();
        write_reg(REG_WIDTH, 32'd4096);
        write_reg(REG_HEIGHT, 32'd4096);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        drain();

        // Random phases, each with a fresh configuration.
        for (phase = 0; phase < 24; phase++) begin
            random_config();
            quiet_tail = (phase >= 21);
            repeat (75) random_pixel();
            drain();
        end

        $display("Checked %0d result beats from %0d pixel beats over", color_board.checked,
                 pixels_sent);
        $display("both gradient modes, extreme frame sizes and out-of-frame pixels.");
        if (color_board.mismatches == 0 && color_board.pending_colors.size() == 0)
            $display("gradient_pattern_generator verification clean");
        else
            $display("gradient_pattern_generator verification failed");
        $finish;
    end
endmodule
